FILE: src/ilc_pkg.sv
// Shared types and constants for the indexed list with capacity tracking.
// Used by ilc_cell, indexed_list_with_capacity and the testbench; depends on nothing else.
`default_nettype none

package ilc_pkg;

  localparam int unsigned MaxEntries = 64;
  localparam int unsigned IdxW       = $clog2(MaxEntries);
  localparam int unsigned CntW       = $clog2(MaxEntries + 1);
  localparam int unsigned WordW      = 32;

  typedef enum logic [2:0] {
    ModeAppend = 3'd0,
    ModeInsert = 3'd1,
    ModeRead   = 3'd2,
    ModeWrite  = 3'd3,
    ModeRemove = 3'd4,
    ModePop    = 3'd5
  } mode_e;

  typedef enum logic [1:0] {
    StatusOk    = 2'd0,
    StatusRange = 2'd1,
    StatusFull  = 2'd2,
    StatusEmpty = 2'd3
  } status_e;

  // Broadcast to every cell during the execute cycle.
  typedef struct packed {
    logic            ins;
    logic            rem;
    logic            wr;
    logic [CntW-1:0] pos;
    logic [CntW-1:0] cnt;
  } ctrl_t;

endpackage

`default_nettype wire

FILE: src/indexed_list_with_capacity.sv
// Top level of the indexed list: request register, control, capacity
// tracking and a row of ilc_cell storage cells. Depends on ilc_pkg, ilc_cell.
//
//   channel   handshake          fields
//   request   start / busy       mode_i, position_i, word_i
//   result    done_o (strobe)    read_word_o, status_o, length_o,
//                                logical_capacity_o
//
// A request beat is taken when start is high and busy is low. The next cycle
// executes it: all cells shift, load or hold at once, and the read value is
// picked from the cells by a wide OR of gated taps. The result beat shows in
// the cycle after that, from the result registers. Reset clears the length
// to zero and the capacity to one; cell contents are not reset. The receiver
// cannot stall.
`default_nettype none

module indexed_list_with_capacity import ilc_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start,
  output logic                    busy,
  input  logic [2:0]              mode_i,
  input  logic [CntW-1:0]         position_i,
  input  logic signed [WordW-1:0] word_i,
  output logic                    done_o,
  output logic signed [WordW-1:0] read_word_o,
  output logic [1:0]              status_o,
  output logic [CntW-1:0]         length_o,
  output logic [CntW-1:0]         logical_capacity_o
);

  localparam logic [CntW-1:0] MaxCnt = CntW'(MaxEntries);

  function automatic logic [CntW-1:0] pow2_ceil(input logic [CntW-1:0] v);
    logic [CntW-1:0] r;
    logic            found;
    logic [CntW:0]   p;
    r     = '0;
    found = 1'b0;
    for (int k = 0; k < CntW; k++) begin
      p = (CntW + 1)'(1) << k;
      if (!found && (p >= {1'b0, v})) begin
        r     = p[CntW-1:0];
        found = 1'b1;
      end
    end
    return r;
  endfunction

  logic                    req_valid_q;
  logic [2:0]              mode_q;
  logic [CntW-1:0]         pos_q;
  logic signed [WordW-1:0] word_q;

  logic [CntW-1:0]         count_d, count_q;
  logic [CntW-1:0]         cap_d, cap_q;

  logic                    done_q;
  logic signed [WordW-1:0] rd_d, rd_q;
  status_e                 st_d;
  logic [1:0]              st_q;

  ctrl_t                   ctrl;
  logic signed [WordW-1:0] cell_val [MaxEntries];
  logic signed [WordW-1:0] cell_tap [MaxEntries];
  logic signed [WordW-1:0] tap_or;

  logic [CntW:0]           cap_dbl;
  logic [CntW-1:0]         cap_grown;
  logic [CntW-1:0]         cnt_dec;
  logic [CntW-1:0]         cap_shrunk;

  assign busy = req_valid_q;

  // Capacity after growth and after shrinking, for use by the control below.
  assign cap_dbl   = {cap_q, 1'b0};
  assign cap_grown = (count_q >= cap_q) ?
                     ((cap_dbl > (CntW + 1)'(MaxEntries)) ? MaxCnt : cap_dbl[CntW-1:0]) :
                     cap_q;
  assign cnt_dec    = count_q - CntW'(1);
  assign cap_shrunk = (({2'b00, cnt_dec} << 2) < (CntW + 2)'(cap_q) &&
                       cnt_dec >= CntW'(2)) ? pow2_ceil(cnt_dec) : cap_q;

  always_comb begin
    tap_or = '0;
    for (int i = 0; i < MaxEntries; i++) begin
      tap_or = tap_or | cell_tap[i];
    end
  end

  always_comb begin
    ctrl     = '0;
    ctrl.pos = pos_q;
    ctrl.cnt = count_q;
    count_d  = count_q;
    cap_d    = cap_q;
    rd_d     = '0;
    st_d     = StatusOk;
    if (req_valid_q) begin
      case (mode_e'(mode_q))
        ModeAppend: begin
          if (count_q == MaxCnt) begin
            st_d = StatusFull;
          end else begin
            ctrl.ins = 1'b1;
            ctrl.pos = count_q;
            count_d  = count_q + CntW'(1);
            cap_d    = cap_grown;
          end
        end
        ModeInsert: begin
          if (pos_q > count_q) begin
            st_d = StatusRange;
          end else if (count_q == MaxCnt) begin
            st_d = StatusFull;
          end else begin
            ctrl.ins = 1'b1;
            count_d  = count_q + CntW'(1);
            cap_d    = cap_grown;
          end
        end
        ModeRead: begin
          if (pos_q >= count_q) begin
            st_d = StatusRange;
          end else begin
            rd_d = tap_or;
          end
        end
        ModeWrite: begin
          if (pos_q >= count_q) begin
            st_d = StatusRange;
          end else begin
            ctrl.wr = 1'b1;
          end
        end
        ModeRemove: begin
          if (count_q == '0) begin
            st_d = StatusEmpty;
          end else if (pos_q >= count_q) begin
            st_d = StatusRange;
          end else begin
            ctrl.rem = 1'b1;
            rd_d     = tap_or;
            count_d  = cnt_dec;
            cap_d    = cap_shrunk;
          end
        end
        ModePop: begin
          ctrl.pos = cnt_dec;
          if (count_q == '0) begin
            st_d = StatusEmpty;
          end else begin
            ctrl.rem = 1'b1;
            rd_d     = tap_or;
            count_d  = cnt_dec;
            cap_d    = cap_shrunk;
          end
        end
        default: begin
        end
      endcase
    end
  end

  for (genvar g = 0; g < MaxEntries; g++) begin : g_cell
    logic signed [WordW-1:0] left, right;
    if (g == 0) begin : g_first
      assign left = '0;
    end else begin : g_inner_l
      assign left = cell_val[g-1];
    end
    if (g == MaxEntries - 1) begin : g_last
      assign right = '0;
    end else begin : g_inner_r
      assign right = cell_val[g+1];
    end
    ilc_cell u_cell (
      .clk_i      (clk_i),
      .ctrl_i     (ctrl),
      .idx_i      (IdxW'(g)),
      .new_word_i (word_q),
      .left_i     (left),
      .right_i    (right),
      .value_o    (cell_val[g]),
      .tap_o      (cell_tap[g])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q <= 1'b0;
      count_q     <= '0;
      cap_q       <= CntW'(1);
      done_q      <= 1'b0;
    end else begin
      req_valid_q <= start && !req_valid_q;
      count_q     <= count_d;
      cap_q       <= cap_d;
      done_q      <= req_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start && !req_valid_q) begin
      mode_q <= mode_i;
      pos_q  <= position_i;
      word_q <= word_i;
    end
    if (req_valid_q) begin
      rd_q <= rd_d;
      st_q <= st_d;
    end
  end

  assign done_o             = done_q;
  assign read_word_o        = rd_q;
  assign status_o           = st_q;
  assign length_o           = count_q;
  assign logical_capacity_o = cap_q;

endmodule

`default_nettype wire

FILE: src/ilc_cell.sv
// One storage cell of the list: holds a word and takes it from the request,
// from its left neighbor (insert) or from its right neighbor (remove).
// Depends on ilc_pkg.
`default_nettype none

module ilc_cell import ilc_pkg::*; (
  input  logic                    clk_i,
  input  ctrl_t                   ctrl_i,
  input  logic [IdxW-1:0]         idx_i,
  input  logic signed [WordW-1:0] new_word_i,
  input  logic signed [WordW-1:0] left_i,
  input  logic signed [WordW-1:0] right_i,
  output logic signed [WordW-1:0] value_o,
  output logic signed [WordW-1:0] tap_o
);

  logic signed [WordW-1:0] value_d, value_q;
  logic [CntW-1:0]         idx;
  logic                    hit;

  assign idx = CntW'(idx_i);
  assign hit = (idx == ctrl_i.pos);

  always_comb begin
    value_d = value_q;
    if (ctrl_i.ins) begin
      if (hit) begin
        value_d = new_word_i;
      end else if ((idx > ctrl_i.pos) && (idx <= ctrl_i.cnt)) begin
        value_d = left_i;
      end
    end else if (ctrl_i.rem) begin
      // The removed entry and every entry above it but the last take the next one up.
      if ((idx >= ctrl_i.pos) && ((idx + CntW'(1)) < ctrl_i.cnt)) begin
        value_d = right_i;
      end
    end else if (ctrl_i.wr && hit) begin
      value_d = new_word_i;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign value_o = value_q;
  assign tap_o   = hit ? value_q : '0;

endmodule

`default_nettype wire

FILE: dv/tb_indexed_list_with_capacity.sv
// Self-checking testbench for indexed_list_with_capacity: directed corner requests, then
// random fill, drain and mixed phases checked against a cycle-free mirror of the list.
// Depends on ilc_pkg and the RTL under src/.

module tb_indexed_list_with_capacity;
  timeunit 1ns;
  timeprecision 1ps;

  import ilc_pkg::*;

  localparam logic [2:0] ModeSpare6 = 3'd6;
  localparam logic [2:0] ModeSpare7 = 3'd7;
  localparam int RequestTarget = 1650;
  localparam int CycleLimit    = 500_000;
  localparam int PhaseItemCap  = 200;

  typedef enum int {PhaseFill, PhaseMixed, PhaseDrain} phase_e;

  typedef struct {
    logic signed [WordW-1:0] read_word;
    status_e                 status;
    logic [CntW-1:0]         length;
    logic [CntW-1:0]         capacity;
  } reply_t;

  // Mirror of the list contents and capacity; each accepted request turns into
  // one awaited reply, matched in order against the result strobes.
  class list_mirror;
    logic signed [WordW-1:0] cells [MaxEntries];
    int unsigned len;
    int unsigned cap;
    reply_t awaited [$];
    int faults;

    function new();
      len    = 0;
      cap    = 1;
      faults = 0;
    endfunction

    function int pending();
      return awaited.size();
    endfunction

    function void grow();
      if (len >= cap) cap = (cap * 2 > MaxEntries) ? MaxEntries : cap * 2;
    endfunction

    function logic signed [WordW-1:0] take_at(int unsigned idx);
      logic signed [WordW-1:0] old;
      int unsigned p;
      old = cells[idx];
      for (int unsigned i = idx; i + 1 < len; i++) cells[i] = cells[i + 1];
      len--;
      // The capacity shrinks once fewer than a quarter of the slots are used and at least two entries remain.
      if (4 * len < cap && len >= 2) begin
        p = 1;
        while (p < len) p = p << 1;
        cap = p;
      end
      return old;
    endfunction

    function void note_request(logic [2:0] mode, logic [CntW-1:0] pos,
                               logic signed [WordW-1:0] word);
      reply_t r;
      r.read_word = '0;
      r.status    = StatusOk;
      case (mode)
        ModeAppend: begin
          if (len >= MaxEntries) begin
            r.status = StatusFull;
          end else begin
            grow();
            cells[len] = word;
            len++;
          end
        end
        ModeInsert: begin
          if (pos > len) begin
            r.status = StatusRange;
          end else if (len >= MaxEntries) begin
            r.status = StatusFull;
          end else begin
            grow();
            for (int unsigned i = len; i > pos; i--) cells[i] = cells[i - 1];
            cells[pos] = word;
            len++;
          end
        end
        ModeRead: begin
          if (pos >= len) r.status = StatusRange;
          else r.read_word = cells[pos];
        end
        ModeWrite: begin
          if (pos >= len) r.status = StatusRange;
          else cells[pos] = word;
        end
        ModeRemove: begin
          if (len == 0) r.status = StatusEmpty;
          else if (pos >= len) r.status = StatusRange;
          else r.read_word = take_at(pos);
        end
        ModePop: begin
          if (len == 0) r.status = StatusEmpty;
          else r.read_word = take_at(len - 1);
        end
        default: begin
        end
      endcase
      r.length   = CntW'(len);
      r.capacity = CntW'(cap);
      awaited.push_back(r);
    endfunction

    function void check_result(logic signed [WordW-1:0] rd, logic [1:0] st,
                               logic [CntW-1:0] length, logic [CntW-1:0] capacity);
      reply_t r;
      if (awaited.size() == 0) begin
        $error("result beat with no request outstanding");
        faults++;
        return;
      end
      r = awaited.pop_front();
      if (rd !== r.read_word) begin
        $error("read_word: expected %0d, got %0d", r.read_word, rd);
        faults++;
      end
      if (st !== r.status) begin
        $error("status: expected %0d, got %0d", r.status, st);
        faults++;
      end
      if (length !== r.length) begin
        $error("length: expected %0d, got %0d", r.length, length);
        faults++;
      end
      if (capacity !== r.capacity) begin
        $error("logical_capacity: expected %0d, got %0d", r.capacity, capacity);
        faults++;
      end
    endfunction
  endclass

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    start = 1'b0;
  logic                    busy;
  logic [2:0]              mode_i = '0;
  logic [CntW-1:0]         position_i = '0;
  logic signed [WordW-1:0] word_i = '0;
  logic                    done_o;
  logic signed [WordW-1:0] read_word_o;
  logic [1:0]              status_o;
  logic [CntW-1:0]         length_o;
  logic [CntW-1:0]         logical_capacity_o;

  list_mirror mirror = new();
  int requests_sent = 0;
  int cycle_count = 0;

  indexed_list_with_capacity uut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .start              (start),
    .busy               (busy),
    .mode_i             (mode_i),
    .position_i         (position_i),
    .word_i             (word_i),
    .done_o             (done_o),
    .read_word_o        (read_word_o),
    .status_o           (status_o),
    .length_o           (length_o),
    .logical_capacity_o (logical_capacity_o)
  );

  always #10 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      mirror.check_result(read_word_o, status_o, length_o, logical_capacity_o);
    end
  end

  // Mostly back to back or short pauses, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(3, 1);
    return $urandom_range(40, 5);
  endfunction

  function automatic logic signed [WordW-1:0] pick_word();
    case ($urandom_range(9))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return '0;
      default: return $urandom;
    endcase
  endfunction

  // Holds the beat until busy is low at a clock edge, then pauses for the given gap.
  task automatic send_request(input logic [2:0] mode, input logic [CntW-1:0] pos,
                              input logic signed [WordW-1:0] word, input int gap);
    start      <= 1'b1;
    mode_i     <= mode;
    position_i <= pos;
    word_i     <= word;
    do @(posedge clk_i); while (busy);
    mirror.note_request(mode, pos, word);
    if (mode <= ModePop) requests_sent++;
    if (gap > 0) begin
      start      <= 1'b0;
      mode_i     <= 3'($urandom);
      position_i <= CntW'($urandom);
      word_i     <= $urandom;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic wait_for_quiet();
    start <= 1'b0;
    do @(posedge clk_i); while (mirror.pending() != 0);
  endtask

  task automatic issue_random(input phase_e kind, input bit burst);
    int r;
    int unsigned hi;
    logic [2:0] mode;
    logic [CntW-1:0] pos;
    r = $urandom_range(99);
    case (kind)
      PhaseFill: begin
        if (r < 45) mode = ModeAppend;
        else if (r < 75) mode = ModeInsert;
        else if (r < 82) mode = ModeRead;
        else if (r < 90) mode = ModeWrite;
        else if (r < 95) mode = ModeRemove;
        else mode = ModePop;
      end
      PhaseDrain: begin
        if (r < 5) mode = ModeAppend;
        else if (r < 10) mode = ModeInsert;
        else if (r < 20) mode = ModeRead;
        else if (r < 30) mode = ModeWrite;
        else if (r < 65) mode = ModeRemove;
        else mode = ModePop;
      end
      default: begin
        if (r < 1) mode = ModeSpare6;
        else if (r < 2) mode = ModeSpare7;
        else mode = 3'($urandom_range(ModePop, ModeAppend));
      end
    endcase
    // Highest legal index; insert may also go one past the last entry.
    if (mode == ModeInsert) hi = mirror.len;
    else hi = (mirror.len == 0) ? 0 : mirror.len - 1;
    r = $urandom_range(99);
    if (r < 10 && hi < MaxEntries) pos = CntW'($urandom_range(MaxEntries, hi + 1));
    else if (r < 18) pos = '0;
    else if (r < 25) pos = CntW'(hi);
    else pos = CntW'($urandom_range(hi, 0));
    send_request(mode, pos, pick_word(), burst ? 0 : pick_gap());
  endtask

  // Runs until the list reaches the given length, then one to six more requests
  // so that the full or empty case is hit, but stops at PhaseItemCap requests.
  task automatic run_to_length(input phase_e kind, input int unsigned goal, input bit burst);
    int n;
    int extra;
    n = 0;
    extra = -1;
    while (n < PhaseItemCap && extra != 0) begin
      if (extra < 0 && mirror.len == goal) extra = $urandom_range(6, 1);
      issue_random(kind, burst);
      n++;
      if (extra > 0) extra--;
    end
  endtask

  initial begin
    int phase_idx;
    int steps;
    bit burst;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Empty list: the empty and range error paths first, then the unused modes.
    send_request(ModePop, '0, '0, pick_gap());
    send_request(ModeRemove, '0, '0, pick_gap());
    send_request(ModeRead, '0, '0, pick_gap());
    send_request(ModeWrite, '0, 32'h0000_1234, pick_gap());
    send_request(ModeInsert, 7'd1, 32'sd5, pick_gap());
    send_request(ModeInsert, 7'd64, 32'sd5, pick_gap());
    send_request(ModeSpare6, 7'd3, -32'sd1, pick_gap());
    send_request(ModeSpare7, 7'd127, 32'h7FFF_FFFF, pick_gap());
    // Build five entries, growing the capacity through 1, 2, 4 and 8.
    send_request(ModeAppend, '0, 32'h7FFF_FFFF, pick_gap());
    send_request(ModeAppend, 7'd64, 32'h8000_0000, pick_gap());
    send_request(ModeInsert, '0, '0, pick_gap());
    send_request(ModeInsert, 7'd3, -32'sd1, pick_gap());
    send_request(ModeInsert, 7'd2, 32'h5A5A_5A5A, pick_gap());
    send_request(ModeRead, '0, '0, pick_gap());
    send_request(ModeRead, 7'd4, '0, pick_gap());
    send_request(ModeRead, 7'd5, '0, pick_gap());
    send_request(ModeRead, 7'd64, '0, pick_gap());
    send_request(ModeWrite, 7'd2, 32'h0F0F_0F0F, pick_gap());
    send_request(ModeRead, 7'd2, '0, pick_gap());
    // Take everything back out, the index check and the empty pop included.
    send_request(ModeRemove, 7'd5, '0, pick_gap());
    send_request(ModeRemove, '0, '0, pick_gap());
    send_request(ModePop, '0, '0, pick_gap());
    send_request(ModeRemove, 7'd1, '0, pick_gap());
    send_request(ModePop, '0, '0, pick_gap());
    send_request(ModeRemove, '0, '0, pick_gap());
    send_request(ModePop, '0, '0, pick_gap());
    wait_for_quiet();

    phase_idx = 0;
    while (requests_sent < RequestTarget) begin
      burst = ($urandom_range(3) == 0);
      case (phase_idx % 4)
        0: run_to_length(PhaseFill, MaxEntries, burst);
        2: run_to_length(PhaseDrain, 0, burst);
        default: begin
          steps = $urandom_range(80, 20);
          repeat (steps) issue_random(PhaseMixed, burst);
        end
      endcase
      if (phase_idx % 3 == 2) wait_for_quiet();
      phase_idx++;
    end

    wait_for_quiet();
    repeat (8) @(posedge clk_i);
    if (mirror.pending() != 0) begin
      $error("%0d results never arrived", mirror.pending());
      mirror.faults++;
    end
    if (mirror.faults == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
